// ===== sv/ale_pkg.sv =====
// ----------------------------------------------------------------------------
// ale_pkg
// shared constants, codes and types of the array list engine
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam int DEPTH  = 128;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = 8;
    localparam int POS_W  = 8;
    localparam int DATA_W = 32;
    localparam int FIDX_W = 7;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT  = 3'd0,
        ACT_DEL_POS = 3'd1,
        ACT_DEL_VAL = 3'd2,
        ACT_SEARCH  = 3'd3,
        ACT_UPDATE  = 3'd4,
        ACT_READ    = 3'd5
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PUT,
        S_DOWN,
        S_SCAN,
        S_RDWAIT,
        S_DONE
    } fsm_t;

    // one write port and one read port of the entry store
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

endpackage

// ===== sv/ale_store.sv =====
// ----------------------------------------------------------------------------
// ale_store
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module ale_store
    import ale_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/array_list_engine.sv =====
// ----------------------------------------------------------------------------
// array_list_engine
// dense ordered list of signed 32-bit words with insert, delete, search,
// update and read, one action per input transfer
// ----------------------------------------------------------------------------
// usage
//   input channel  : in_valid / in_ready, payload action, position, value
//   output channel : out_valid / out_ready, payload status, found_index,
//                    read_value, count; exactly one result per input transfer
//   items are worked one at a time; in_ready is high only while the engine
//   is idle, so a new transfer can be taken while the last result still
//   waits in the output register
//   the walk through the entry memory, with its one write and one read
//   port, moves one entry per cycle: insert and delete at a position shift
//   the entries from that position to the end of the list, search scans
//   from the head up to the first match or the end, and delete by value
//   scans the same way and then closes the gap; the next transfer can be
//   taken in the cycle after the result is loaded
//   reset clears the count and the handshake state; entry contents are
//   undefined but are never read below the count before being written
//   a stalled receiver holds the result; the engine finishes its next item
//   and then waits with it until the output register frees
// ----------------------------------------------------------------------------
module array_list_engine
    import ale_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ACT_W-1:0]         action,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STAT_W-1:0]        status,
    output logic [FIDX_W-1:0]        found_index,
    output logic signed [DATA_W-1:0] read_value,
    output logic [CNT_W-1:0]         count
);

    // control state
    fsm_t               state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;

    // working registers of the current item
    action_t            act_reg, act_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [IDX_W-1:0]   pend_addr_reg, pend_addr_next;
    status_t            res_status_reg, res_status_next;
    logic [FIDX_W-1:0]  res_index_reg, res_index_next;
    logic [DATA_W-1:0]  res_value_reg, res_value_next;

    // output register
    status_t            out_status_reg, out_status_next;
    logic [FIDX_W-1:0]  out_index_reg, out_index_next;
    logic [DATA_W-1:0]  out_value_reg, out_value_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;

    mem_req_t           mem_req;
    logic [DATA_W-1:0]  rdata;

    action_t            in_act;
    logic               in_fire;
    logic               out_free;
    logic               ins_full;
    logic               ins_bad;
    logic               pos_bad;
    logic [CNT_W-1:0]   ptr_inc;
    logic [CNT_W-1:0]   ptr_dec;
    logic               up_more;
    logic               down_more;
    logic               scan_more;
    logic               scan_hit;

    ale_store u_store
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    assign in_act    = action_t'(action);
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // acceptance checks against the current count
    assign ins_full  = (cnt_reg >= CNT_W'(DEPTH));
    assign ins_bad   = (position > cnt_reg);
    assign pos_bad   = (position >= cnt_reg);

    // walk pointer helpers
    assign ptr_inc   = ptr_reg + CNT_W'(1);
    assign ptr_dec   = ptr_reg - CNT_W'(1);
    assign up_more   = (ptr_reg > pos_reg);
    assign down_more = (ptr_inc < cnt_reg);
    assign scan_more = (ptr_reg < cnt_reg);
    // read data is valid in the cycle after a read was issued
    assign scan_hit  = pend_reg && (rdata == val_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_act)
                        ACT_INSERT:  state_next = (ins_full || ins_bad) ? S_DONE : S_UP;
                        ACT_DEL_POS: state_next = pos_bad ? S_DONE : S_DOWN;
                        ACT_DEL_VAL: state_next = S_SCAN;
                        ACT_SEARCH:  state_next = S_SCAN;
                        ACT_READ:    state_next = pos_bad ? S_DONE : S_RDWAIT;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_UP:
            begin
                if (!up_more)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                state_next = S_DONE;
            end
            S_DOWN:
            begin
                if (!down_more)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = (act_reg == ACT_DEL_VAL) ? S_DOWN : S_DONE;
                end
                else if (!scan_more && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_RDWAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, memory access and output register
    always_comb
    begin
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        act_next        = act_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        ptr_next        = ptr_reg;
        pend_addr_next  = pend_addr_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;

        mem_req         = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    act_next        = in_act;
                    pos_next        = position;
                    val_next        = value;
                    pend_next       = 1'b0;
                    ptr_next        = '0;
                    res_status_next = ST_OK;
                    res_index_next  = '0;
                    res_value_next  = '0;
                    case (in_act)
                        ACT_INSERT:
                        begin
                            ptr_next = cnt_reg;
                            if (ins_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (ins_bad)
                            begin
                                res_status_next = ST_BAD_POS;
                            end
                        end
                        ACT_DEL_POS:
                        begin
                            ptr_next = position;
                            if (pos_bad)
                            begin
                                res_status_next = ST_BAD_POS;
                            end
                        end
                        ACT_UPDATE:
                        begin
                            if (pos_bad)
                            begin
                                res_status_next = ST_BAD_POS;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = position[IDX_W-1:0];
                                mem_req.wdata = value;
                            end
                        end
                        ACT_READ:
                        begin
                            if (pos_bad)
                            begin
                                res_status_next = ST_BAD_POS;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = position[IDX_W-1:0];
                            end
                        end
                        default:
                        begin
                            ptr_next = '0;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // read entry below the pointer, write it one place up next cycle
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pend_addr_reg;
                    mem_req.wdata = rdata;
                end
                if (up_more)
                begin
                    mem_req.re     = 1'b1;
                    mem_req.raddr  = ptr_dec[IDX_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_dec;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg[IDX_W-1:0];
                mem_req.wdata = val_reg;
                cnt_next      = cnt_reg + CNT_W'(1);
            end
            S_DOWN:
            begin
                // read entry above the pointer, write it one place down next cycle
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pend_addr_reg;
                    mem_req.wdata = rdata;
                end
                if (down_more)
                begin
                    mem_req.re     = 1'b1;
                    mem_req.raddr  = ptr_inc[IDX_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                    cnt_next  = cnt_reg - CNT_W'(1);
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    // first match; no further read is issued
                    res_index_next = FIDX_W'(pend_addr_reg);
                    ptr_next       = CNT_W'(pend_addr_reg);
                    pend_next      = 1'b0;
                end
                else if (scan_more)
                begin
                    mem_req.re     = 1'b1;
                    mem_req.raddr  = ptr_reg[IDX_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_inc;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                end
            end
            S_RDWAIT:
            begin
                res_value_next = rdata;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    out_value_next  = res_value_reg;
                    out_count_next  = cnt_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        ptr_reg        <= ptr_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_index = out_index_reg;
    assign read_value  = out_value_reg;
    assign count       = out_count_reg;

endmodule

// ===== tb/list_shadow_check.sv =====
// ----------------------------------------------------------------------------
// list_shadow_check
// watches both channels of the array list engine, keeps a shadow copy of the
// list, predicts every result and compares it with what comes out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module list_shadow_check
    import ale_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [ACT_W-1:0]         action,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [STAT_W-1:0]        status,
    input  logic [FIDX_W-1:0]        found_index,
    input  logic signed [DATA_W-1:0] read_value,
    input  logic [CNT_W-1:0]         count,
    output int                       mismatches,
    output int                       waiting,
    output int                       checked,
    output int                       shadow_len,
    output int                       peak_len,
    output int                       full_rejects
);

    typedef struct packed {
        logic [STAT_W-1:0] st;
        logic [FIDX_W-1:0] idx;
        logic [DATA_W-1:0] rd;
        logic [CNT_W-1:0]  cnt;
    } list_result_t;

    logic [DATA_W-1:0] shadow_mem [DEPTH];
    int                shadow_count = 0;
    list_result_t      due_q [$];

    // close the gap left by entry p
    function automatic void drop_entry(input int p);
        for (int i = p; i + 1 < shadow_count; i++)
            shadow_mem[i] = shadow_mem[i + 1];
        shadow_count--;
    endfunction

    // apply one action to the shadow list and return its result
    function automatic list_result_t apply_action(input logic [ACT_W-1:0] act,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [DATA_W-1:0] val);
        list_result_t r;
        int           p;
        int           hit;
        r   = '0;
        p   = pos;
        hit = -1;
        case (act)
            ACT_INSERT:
            begin
                if (shadow_count >= DEPTH)
                    r.st = ST_FULL;
                else if (p > shadow_count)
                    r.st = ST_BAD_POS;
                else
                begin
                    for (int i = shadow_count; i > p; i--)
                        shadow_mem[i] = shadow_mem[i - 1];
                    shadow_mem[p] = val;
                    shadow_count++;
                end
            end
            ACT_DEL_POS:
            begin
                if (p >= shadow_count)
                    r.st = ST_BAD_POS;
                else
                    drop_entry(p);
            end
            ACT_DEL_VAL, ACT_SEARCH:
            begin
                for (int i = 0; i < shadow_count && hit < 0; i++)
                    if (shadow_mem[i] == val)
                        hit = i;
                if (hit < 0)
                    r.st = ST_NOT_FOUND;
                else
                begin
                    r.idx = hit[FIDX_W-1:0];
                    if (act == ACT_DEL_VAL)
                        drop_entry(hit);
                end
            end
            ACT_UPDATE:
            begin
                if (p >= shadow_count)
                    r.st = ST_BAD_POS;
                else
                    shadow_mem[p] = val;
            end
            ACT_READ:
            begin
                if (p >= shadow_count)
                    r.st = ST_BAD_POS;
                else
                    r.rd = shadow_mem[p];
            end
            default: ;
        endcase
        r.cnt = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        list_result_t got;
        if (!rst_n)
        begin
            shadow_count = 0;
            due_q.delete();
            mismatches   = 0;
            checked      = 0;
            peak_len     = 0;
            full_rejects = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{status, found_index, read_value, count};
                checked++;
                if (due_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d index %0d value %h count %0d",
                                 got.st, got.idx, got.rd, got.cnt);
                end
                else
                begin
                    want = due_q.pop_front();
                    if (got.st != want.st || got.idx != want.idx ||
                        got.rd != want.rd || got.cnt != want.cnt)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("mismatch on result %0d (expected/actual): status %0d/%0d ",
                                   checked, want.st, got.st);
                            $display("index %0d/%0d value %h/%h count %0d/%0d",
                                     want.idx, got.idx, want.rd, got.rd, want.cnt, got.cnt);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want = apply_action(action, position, value);
                if (want.st == ST_FULL)
                    full_rejects++;
                due_q.push_back(want);
                if (shadow_count > peak_len)
                    peak_len = shadow_count;
            end
        end
        waiting    = due_q.size();
        shadow_len = shadow_count;
    end

endmodule

// ===== tb/tb_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// tb_array_list_engine
// stimulus and verdict for the array list engine: a directed opening over
// the edge cases, random mixing and filling to capacity, directed actions
// on the full list and random draining, with random idling on both
// channels; list_shadow_check predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_array_list_engine;
    import ale_pkg::*;

    // codes the engine must ignore
    localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

    // worst walk of one item plus margin, used for the final settle
    localparam int SETTLE_CYCLES = 2 * DEPTH + 20;

    // steering of the random part
    typedef enum int {
        MIX_MODE,
        FILL_MODE,
        DRAIN_MODE
    } stim_mode_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic [STAT_W-1:0]        status;
    logic [FIDX_W-1:0]        found_index;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         count;

    int mismatches;
    int waiting;
    int checked;
    int shadow_len;
    int peak_len;
    int full_rejects;

    // when set, neither side idles: back-to-back stretches
    bit calm = 1'b0;
    int items_sent = 0;

    // small value pool so that searches and deletes by value often hit
    logic [DATA_W-1:0] value_pool [8];

    array_list_engine u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_index (found_index),
        .read_value  (read_value),
        .count       (count)
    );

    list_shadow_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .position     (position),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .found_index  (found_index),
        .read_value   (read_value),
        .count        (count),
        .mismatches   (mismatches),
        .waiting      (waiting),
        .checked      (checked),
        .shadow_len   (shadow_len),
        .peak_len     (peak_len),
        .full_rejects (full_rejects)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop far beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("timeout with %0d results still due", waiting);
        $display("FAILURE");
        $finish;
    end

    // one input transfer; entered at a falling edge, returns at the falling
    // edge after the transfer so the shadow length is settled for the caller
    task automatic drive_item(input logic [ACT_W-1:0] act,
                              input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        // switch between idling and back-to-back stretches now and then
        if (items_sent % 32 == 0)
            calm = ($urandom_range(0, 3) == 0);
    endtask

    // one random transfer, shaped by the current phase
    task automatic random_item(input stim_mode_t mode);
        int                roll;
        int                len;
        logic [ACT_W-1:0]  act;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        len  = shadow_len;
        roll = $urandom_range(0, 99);
        case (mode)
            MIX_MODE:
            begin
                if (roll < 30)      act = ACT_INSERT;
                else if (roll < 42) act = ACT_DEL_POS;
                else if (roll < 52) act = ACT_DEL_VAL;
                else if (roll < 66) act = ACT_SEARCH;
                else if (roll < 78) act = ACT_UPDATE;
                else if (roll < 94) act = ACT_READ;
                else if (roll < 97) act = ACT_SPARE6;
                else                act = ACT_SPARE7;
            end
            FILL_MODE:
            begin
                if (roll < 80)      act = ACT_INSERT;
                else if (roll < 88) act = ACT_SEARCH;
                else if (roll < 96) act = ACT_READ;
                else                act = ACT_UPDATE;
            end
            default:
            begin
                if (roll < 70)      act = ACT_DEL_POS;
                else if (roll < 85) act = ACT_DEL_VAL;
                else if (roll < 90) act = ACT_SEARCH;
                else if (roll < 95) act = ACT_READ;
                else                act = ACT_UPDATE;
            end
        endcase
        // pool values most of the time, any 32-bit word otherwise
        if ($urandom_range(0, 99) < 65)
            val = value_pool[$urandom_range(0, 7)];
        else
            val = $urandom();
        // mostly legal positions, some anywhere in the 8-bit range
        if ($urandom_range(0, 9) < 2)
            pos = POS_W'($urandom_range(0, 255));
        else if (act == ACT_INSERT)
            pos = POS_W'($urandom_range(0, len));
        else if (len > 0)
            pos = POS_W'($urandom_range(0, len - 1));
        else
            pos = '0;
        drive_item(act, pos, val);
    endtask

    // receiver: draws a stall before each result
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 11);
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        action   = '0;
        position = '0;
        value    = '0;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list: every position is out of range, nothing can match
        drive_item(ACT_READ,    8'd0,   32'h0000_0000);
        drive_item(ACT_DEL_POS, 8'd0,   32'h0000_0000);
        drive_item(ACT_SEARCH,  8'd0,   32'h0000_1234);
        drive_item(ACT_DEL_VAL, 8'd0,   32'h0000_1234);
        drive_item(ACT_UPDATE,  8'd0,   32'hDEAD_BEEF);
        drive_item(ACT_INSERT,  8'd1,   32'h0BAD_0BAD);
        // build 8000_0000, FFFF_FFFF, 7FFF_FFFF, 0 via head, append and middle
        drive_item(ACT_INSERT,  8'd0,   32'h7FFF_FFFF);
        drive_item(ACT_INSERT,  8'd0,   32'h8000_0000);
        drive_item(ACT_INSERT,  8'd2,   32'h0000_0000);
        drive_item(ACT_INSERT,  8'd1,   32'hFFFF_FFFF);
        drive_item(ACT_INSERT,  8'hFF,  32'h1111_1111);
        drive_item(ACT_READ,    8'd0,   32'h0000_0000);
        drive_item(ACT_READ,    8'd3,   32'hFFFF_FFFF);
        drive_item(ACT_READ,    8'd4,   32'h0000_0000);
        // search hits at the tail and in the middle
        drive_item(ACT_SEARCH,  8'd0,   32'h0000_0000);
        drive_item(ACT_SEARCH,  8'hFF,  32'hFFFF_FFFF);
        drive_item(ACT_UPDATE,  8'd2,   32'h5555_5555);
        drive_item(ACT_UPDATE,  8'd4,   32'hAAAA_AAAA);
        drive_item(ACT_READ,    8'd2,   32'h0000_0000);
        // unused codes leave everything alone
        drive_item(ACT_SPARE6,  8'hAA,  32'hAAAA_AAAA);
        drive_item(ACT_SPARE7,  8'h55,  32'h5555_5555);
        // delete by value at the head, delete at the tail, delete past the end
        drive_item(ACT_DEL_VAL, 8'd0,   32'h8000_0000);
        drive_item(ACT_DEL_POS, 8'd2,   32'h0000_0000);
        drive_item(ACT_DEL_POS, 8'd128, 32'h0000_0000);
        drive_item(ACT_READ,    8'd1,   32'h0000_0000);

        // mixed traffic on a short list
        repeat (30)
            random_item(MIX_MODE);

        // grow to capacity
        while (shadow_len < DEPTH)
            random_item(FILL_MODE);

        // full list: capacity check wins over the position check
        drive_item(ACT_INSERT,  8'd0,   32'h1234_5678);
        drive_item(ACT_INSERT,  8'd128, 32'h1234_5678);
        drive_item(ACT_INSERT,  8'd200, 32'h1234_5678);
        drive_item(ACT_UPDATE,  8'd127, 32'h8000_0001);
        drive_item(ACT_READ,    8'd127, 32'h0000_0000);
        drive_item(ACT_READ,    8'd128, 32'h0000_0000);
        drive_item(ACT_SEARCH,  8'd0,   32'h8000_0001);
        drive_item(ACT_DEL_VAL, 8'd0,   32'h8000_0001);

        // shrink back down, then a last mixed stretch
        while (shadow_len > 24)
            random_item(DRAIN_MODE);
        repeat (20)
            random_item(MIX_MODE);

        in_valid <= 1'b0;

        // every result in, then let the engine settle
        while (waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d input transfers and %0d checked results", items_sent, checked);
        $display("list peaked at %0d of %0d entries, %0d inserts refused as full",
                 peak_len, DEPTH, full_rejects);
        if (mismatches == 0 && waiting == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ale_pkg.sv
sv/ale_store.sv
sv/array_list_engine.sv
tb/list_shadow_check.sv
tb/tb_array_list_engine.sv
